// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL, included by double_ended_queue.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, masked while rst_n is low.
`define DQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define DQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/dq_pkg.sv =====
package dq_pkg;

  localparam int DEPTH     = 1024;
  localparam int WORD_BITS = 32;
  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  // Port field widths
  localparam int REQ_BITS     = 3;
  localparam int VAL_BITS     = 32;
  localparam int STAT_BITS    = 2;
  localparam int CNT_OUT_BITS = 11;

  localparam logic signed [VAL_BITS-1:0] NONE_VALUE = '1;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_QUERY      = 3'd4
  } req_t;

  typedef enum logic [STAT_BITS-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  function automatic logic [ADDR_BITS-1:0] idx_inc(input logic [ADDR_BITS-1:0] i);
    return (i == ADDR_BITS'(DEPTH - 1)) ? '0 : ADDR_BITS'(i + 1'b1);
  endfunction

  function automatic logic [ADDR_BITS-1:0] idx_dec(input logic [ADDR_BITS-1:0] i);
    return (i == '0) ? ADDR_BITS'(DEPTH - 1) : ADDR_BITS'(i - 1'b1);
  endfunction

  function automatic logic [WORD_BITS-1:0] to_word(input logic [VAL_BITS-1:0] v);
    return WORD_BITS'(v);
  endfunction

  // sign-extend a stored word, then cut to the port width
  function automatic logic signed [VAL_BITS-1:0] word_out(input logic [WORD_BITS-1:0] w);
    return VAL_BITS'(signed'(w));
  endfunction

endpackage

// ===== hdl/dq_ram.sv =====
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/double_ended_queue.sv =====
// Double-ended queue of signed words held in a ring buffer RAM.
// Input channel (in_valid / in_stall): one request per transfer, carrying
// in_req_type (push front, push back, pop front, pop back, query) and
// in_push_value. Output channel (out_valid / out_stall): exactly one result
// per request, in request order: popped word, status, count after the
// request, empty flag, and the front and back words after the request.
// Front and back words are cached in registers; the ring RAM has one write
// and one registered read port.
// Pushes, queries, failed pops and pops that leave the queue empty register
// their result the cycle after the transfer. A pop that leaves words behind
// first reads the new front or back entry from the RAM in ST_READ, during
// which in_stall is high, and registers its result when that read returns.
// A new request is taken while the output register drains in the same cycle.
// Reset empties the queue (front index and count cleared); the RAM contents
// are not cleared and need no clearing pass, since only written entries are
// ever read. When out_stall is high the result holds and in_stall rises.
module double_ended_queue (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [dq_pkg::REQ_BITS-1:0]            in_req_type,
  input  logic signed [dq_pkg::VAL_BITS-1:0]     in_push_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [dq_pkg::VAL_BITS-1:0]     out_popped_value,
  output logic [dq_pkg::STAT_BITS-1:0]           out_status,
  output logic [dq_pkg::CNT_OUT_BITS-1:0]        out_entry_count,
  output logic                                   out_is_empty,
  output logic signed [dq_pkg::VAL_BITS-1:0]     out_front_value,
  output logic signed [dq_pkg::VAL_BITS-1:0]     out_back_value
);

  import dq_pkg::*;

  state_t                       state_r, state_nxt;
  logic [ADDR_BITS-1:0]         front_idx_r, front_idx_nxt;
  logic [ADDR_BITS-1:0]         back_idx_r, back_idx_nxt;
  logic [CNT_BITS-1:0]          count_r, count_nxt;
  logic [WORD_BITS-1:0]         front_word_r, front_word_nxt;
  logic [WORD_BITS-1:0]         back_word_r, back_word_nxt;
  logic                         pend_front_r, pend_front_nxt;
  logic signed [VAL_BITS-1:0]   pend_popped_r, pend_popped_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic signed [VAL_BITS-1:0]   out_popped_r, out_popped_nxt;
  logic [STAT_BITS-1:0]         out_status_r, out_status_nxt;
  logic [CNT_OUT_BITS-1:0]      out_count_r, out_count_nxt;
  logic                         out_empty_r, out_empty_nxt;
  logic signed [VAL_BITS-1:0]   out_front_r, out_front_nxt;
  logic signed [VAL_BITS-1:0]   out_back_r, out_back_nxt;

  logic                         accept;
  logic                         go_read;
  logic                         load_out;
  logic                         is_empty_now;
  logic                         is_full_now;
  logic                         empty_after;
  logic [WORD_BITS-1:0]         push_word;
  logic signed [VAL_BITS-1:0]   res_popped;
  status_t                      res_status;

  logic                         wr_en;
  logic [ADDR_BITS-1:0]         wr_addr;
  logic                         rd_en;
  logic [ADDR_BITS-1:0]         rd_addr;
  logic [WORD_BITS-1:0]         rd_data;

  dq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (push_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall  = (state_r == ST_READ) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign push_word = to_word(in_push_value);

  assign is_empty_now = (count_r == '0);
  assign is_full_now  = (count_r == CNT_BITS'(DEPTH));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && go_read) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  // Invariant: back index = front index + count - 1 (mod DEPTH), also when empty.
  always_comb begin
    front_idx_nxt   = front_idx_r;
    back_idx_nxt    = back_idx_r;
    count_nxt       = count_r;
    front_word_nxt  = front_word_r;
    back_word_nxt   = back_word_r;
    pend_front_nxt  = pend_front_r;
    pend_popped_nxt = pend_popped_r;
    wr_en           = 1'b0;
    wr_addr         = '0;
    rd_en           = 1'b0;
    rd_addr         = '0;
    go_read         = 1'b0;
    load_out        = 1'b0;
    res_popped      = NONE_VALUE;
    res_status      = STAT_OK;

    if (state_r == ST_IDLE && accept) begin
      unique case (in_req_type)
        REQ_PUSH_FRONT: begin
          if (is_full_now) begin
            res_status = STAT_FULL;
          end else begin
            front_idx_nxt  = idx_dec(front_idx_r);
            wr_en          = 1'b1;
            wr_addr        = front_idx_nxt;
            count_nxt      = CNT_BITS'(count_r + 1'b1);
            front_word_nxt = push_word;
            if (is_empty_now) begin
              back_word_nxt = push_word;
            end
          end
        end
        REQ_PUSH_BACK: begin
          if (is_full_now) begin
            res_status = STAT_FULL;
          end else begin
            back_idx_nxt  = idx_inc(back_idx_r);
            wr_en         = 1'b1;
            wr_addr       = back_idx_nxt;
            count_nxt     = CNT_BITS'(count_r + 1'b1);
            back_word_nxt = push_word;
            if (is_empty_now) begin
              front_word_nxt = push_word;
            end
          end
        end
        REQ_POP_FRONT: begin
          if (is_empty_now) begin
            res_status = STAT_EMPTY;
          end else begin
            res_popped    = word_out(front_word_r);
            front_idx_nxt = idx_inc(front_idx_r);
            count_nxt     = CNT_BITS'(count_r - 1'b1);
            if (count_r != CNT_BITS'(1)) begin
              go_read        = 1'b1;
              rd_en          = 1'b1;
              rd_addr        = front_idx_nxt;
              pend_front_nxt = 1'b1;
            end
          end
        end
        REQ_POP_BACK: begin
          if (is_empty_now) begin
            res_status = STAT_EMPTY;
          end else begin
            res_popped   = word_out(back_word_r);
            back_idx_nxt = idx_dec(back_idx_r);
            count_nxt    = CNT_BITS'(count_r - 1'b1);
            if (count_r != CNT_BITS'(1)) begin
              go_read        = 1'b1;
              rd_en          = 1'b1;
              rd_addr        = back_idx_nxt;
              pend_front_nxt = 1'b0;
            end
          end
        end
        default: ;  // query and unused codes
      endcase
      load_out        = !go_read;
      pend_popped_nxt = res_popped;
    end else if (state_r == ST_READ) begin
      load_out   = 1'b1;
      res_popped = pend_popped_r;
      if (pend_front_r) begin
        front_word_nxt = rd_data;
      end else begin
        back_word_nxt = rd_data;
      end
    end
  end

  assign empty_after = (count_nxt == '0);

  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_popped_nxt = out_popped_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    out_front_nxt  = out_front_r;
    out_back_nxt   = out_back_r;
    if (load_out) begin
      out_valid_nxt  = 1'b1;
      out_popped_nxt = res_popped;
      out_status_nxt = res_status;
      out_count_nxt  = CNT_OUT_BITS'(count_nxt);
      out_empty_nxt  = empty_after;
      out_front_nxt  = empty_after ? NONE_VALUE : word_out(front_word_nxt);
      out_back_nxt   = empty_after ? NONE_VALUE : word_out(back_word_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_idx_r <= '0;
      back_idx_r  <= ADDR_BITS'(DEPTH - 1);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_idx_r <= front_idx_nxt;
      back_idx_r  <= back_idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_word_r  <= front_word_nxt;
    back_word_r   <= back_word_nxt;
    pend_front_r  <= pend_front_nxt;
    pend_popped_r <= pend_popped_nxt;
    out_popped_r  <= out_popped_nxt;
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
    out_empty_r   <= out_empty_nxt;
    out_front_r   <= out_front_nxt;
    out_back_r    <= out_back_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_r;
  assign out_status       = out_status_r;
  assign out_entry_count  = out_count_r;
  assign out_is_empty     = out_empty_r;
  assign out_front_value  = out_front_r;
  assign out_back_value   = out_back_r;

`include "assert_macros.svh"

  `DQ_ASSERT(a_count_range, count_r <= CNT_BITS'(DEPTH), "count beyond depth")
  `DQ_ASSERT(a_read_one_cycle, state_r == ST_READ |=> state_r == ST_IDLE, "read stretched")
  `DQ_ASSERT(a_read_out_free, state_r == ST_READ |-> !out_valid_r, "result lost in read")
  `DQ_ASSERT(a_ring_invariant, count_r == '0 |-> idx_inc(back_idx_r) == front_idx_r, "ring idx")
  `DQ_ASSERT(a_no_rw_overlap, !(wr_en && rd_en), "write and read in one cycle")

endmodule

// ===== dv/deque_checker.sv =====
module deque_checker
  import dq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [REQ_BITS-1:0]        in_req_type,
  input  logic signed [VAL_BITS-1:0] in_push_value,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [VAL_BITS-1:0] out_popped_value,
  input  logic [STAT_BITS-1:0]       out_status,
  input  logic [CNT_OUT_BITS-1:0]    out_entry_count,
  input  logic                       out_is_empty,
  input  logic signed [VAL_BITS-1:0] out_front_value,
  input  logic signed [VAL_BITS-1:0] out_back_value,
  output int                         mismatches,
  output int                         outstanding,
  output int                         results_checked,
  output int                         full_drops,
  output int                         empty_pops
);

  typedef struct {
    logic signed [VAL_BITS-1:0] popped;
    status_t                    status;
    logic [CNT_OUT_BITS-1:0]    count;
    logic                       empty;
    logic signed [VAL_BITS-1:0] front;
    logic signed [VAL_BITS-1:0] back;
  } deque_result_t;

  deque_result_t pending_results[$];
  deque_result_t want;

  // shadow deque
  logic [WORD_BITS-1:0] ring_words [DEPTH];
  int unsigned          head_slot;
  int unsigned          word_count;

  function automatic logic signed [VAL_BITS-1:0] widen(input logic [WORD_BITS-1:0] w);
    logic signed [WORD_BITS-1:0] s;
    s = w;
    return s;
  endfunction

  function automatic deque_result_t apply_request(input logic [REQ_BITS-1:0] kind,
                                                  input logic [VAL_BITS-1:0] value);
    deque_result_t r;
    int unsigned   slot;
    r.popped = NONE_VALUE;
    r.status = STAT_OK;
    case (kind)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (word_count == DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          if (kind == REQ_PUSH_FRONT) begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            slot = head_slot;
          end else begin
            slot = (head_slot + word_count) % DEPTH;
          end
          ring_words[slot] = WORD_BITS'(value);
          word_count++;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (word_count == 0) begin
          r.status = STAT_EMPTY;
        end else if (kind == REQ_POP_FRONT) begin
          r.popped = widen(ring_words[head_slot]);
          head_slot = (head_slot + 1) % DEPTH;
          word_count--;
        end else begin
          r.popped = widen(ring_words[(head_slot + word_count - 1) % DEPTH]);
          word_count--;
        end
      end
      default: ;  // query and unused codes leave the deque alone
    endcase
    r.count = CNT_OUT_BITS'(word_count);
    r.empty = (word_count == 0);
    if (word_count == 0) begin
      r.front = NONE_VALUE;
      r.back  = NONE_VALUE;
    end else begin
      r.front = widen(ring_words[head_slot]);
      r.back  = widen(ring_words[(head_slot + word_count - 1) % DEPTH]);
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [VAL_BITS-1:0] exp_val,
                             input logic [VAL_BITS-1:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, got_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pending_results.delete();
      head_slot  = 0;
      word_count = 0;
    end else begin
      // a result can never belong to the request taken on the same edge
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected, status %h count %0d",
                   $time, out_status, out_entry_count);
          mismatches++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          check_field("popped_value", want.popped, out_popped_value);
          check_field("status", VAL_BITS'(want.status), VAL_BITS'(out_status));
          check_field("entry_count", VAL_BITS'(want.count), VAL_BITS'(out_entry_count));
          check_field("is_empty", VAL_BITS'(want.empty), VAL_BITS'(out_is_empty));
          check_field("front_value", want.front, out_front_value);
          check_field("back_value", want.back, out_back_value);
          results_checked++;
          if (want.status == STAT_FULL) full_drops++;
          if (want.status == STAT_EMPTY) empty_pops++;
        end
      end
      if (in_valid && !in_stall) begin
        pending_results.insert(pending_results.size(),
                               apply_request(in_req_type, in_push_value));
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import dq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MIXED_ITEMS = 100;

  logic                       clk           = 1'b0;
  logic                       rst_n         = 1'b0;
  logic                       in_valid      = 1'b0;
  logic                       in_stall;
  logic [REQ_BITS-1:0]        in_req_type   = REQ_QUERY;
  logic signed [VAL_BITS-1:0] in_push_value = '0;
  logic                       out_valid;
  logic                       out_stall     = 1'b0;
  logic signed [VAL_BITS-1:0] out_popped_value;
  logic [STAT_BITS-1:0]       out_status;
  logic [CNT_OUT_BITS-1:0]    out_entry_count;
  logic                       out_is_empty;
  logic signed [VAL_BITS-1:0] out_front_value;
  logic signed [VAL_BITS-1:0] out_back_value;

  int mismatches, outstanding, results_checked, full_drops, empty_pops;
  int gap_pct   = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int requests_sent = 0;
  int directed_count = 0;
  int unsigned fill_level = 0;  // rough occupancy, only to steer stimulus

  double_ended_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value)
  );

  deque_checker result_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .results_checked  (results_checked),
    .full_drops       (full_drops),
    .empty_pops       (empty_pops)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [VAL_BITS-1:0] pick_value();
    case ($urandom_range(7))
      0: return {1'b0, {(VAL_BITS-1){1'b1}}};
      1: return {1'b1, {(VAL_BITS-1){1'b0}}};
      2: return '1;
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  // one request transfer; the payload holds until the block takes it
  task automatic send_req(input logic [REQ_BITS-1:0] kind, input logic [VAL_BITS-1:0] value);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= kind;
    in_push_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (kind)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: if (fill_level < DEPTH) fill_level++;
      REQ_POP_FRONT, REQ_POP_BACK:   if (fill_level > 0) fill_level--;
      default: ;
    endcase
    requests_sent++;
  endtask

  task automatic send_mixed(input int push_pct);
    int                  roll;
    logic [REQ_BITS-1:0] kind;
    roll = $urandom_range(99);
    if (roll < push_pct)
      kind = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    else if (roll < 95)
      kind = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
    else if (roll < 98)
      kind = REQ_QUERY;
    else
      kind = REQ_BITS'($urandom_range((1 << REQ_BITS) - 1, REQ_QUERY + 1));
    send_req(kind, pick_value());
  endtask

  initial begin
    gap_pct   = 36;
    stall_pct = 50;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-queue pops, extreme words, both ends, unused codes
    send_req(REQ_QUERY, 32'h1234_5678);
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_POP_BACK, '1);
    send_req(REQ_PUSH_FRONT, 32'h7fff_ffff);
    send_req(REQ_PUSH_BACK, 32'h8000_0000);
    send_req(REQ_QUERY, '0);
    send_req(REQ_PUSH_FRONT, '1);
    send_req(REQ_PUSH_BACK, '0);
    send_req(REQ_PUSH_FRONT, 32'h0000_0001);
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_POP_BACK, '0);
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_POP_BACK, '0);
    send_req(REQ_POP_BACK, '0);   // last word leaves
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_BITS'(REQ_QUERY + 1), 32'hffff_0000);
    send_req(REQ_BITS'(REQ_QUERY + 2), 32'h0000_ffff);
    send_req(REQ_BITS'(REQ_QUERY + 3), '1);
    send_req(REQ_PUSH_BACK, 32'haaaa_aaaa);
    send_req(REQ_PUSH_FRONT, 32'h5555_5555);
    send_req(REQ_PUSH_BACK, 32'h8000_0001);
    send_req(REQ_POP_BACK, '0);
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_POP_FRONT, '0);
    directed_count = requests_sent;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin gap_pct = 36; stall_pct = 50; end
        1: begin gap_pct = 50; stall_pct = 36; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      repeat (MIXED_ITEMS) send_mixed(60);
      repeat (MIXED_ITEMS) send_mixed(40);
      if (phase == 1) begin
        // drain to empty, then pop past it
        while (fill_level > 0) send_mixed(8);
        repeat (4) send_req($urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT, pick_value());
      end
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d requests (%0d directed), checked %0d results under three idle mixes.",
             requests_sent, directed_count, results_checked);
    $display("Saw %0d pushes dropped at capacity and %0d pops on an empty queue.",
             full_drops, empty_pops);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== double_ended_queue.f =====
+incdir+hdl
hdl/dq_pkg.sv
hdl/dq_ram.sv
hdl/double_ended_queue.sv
dv/deque_checker.sv
dv/testbench.sv
